### hw/rtl/dss_pkg.sv
// Shared types and constants for the drive start/stop sequencer.
// Used by the front, queue, back and top modules; depends on nothing.
`default_nettype none

package dss_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_DEVICE_ADDRESS = 3'd0;
  localparam logic [2:0] CFG_RUN_REGISTER   = 3'd1;
  localparam logic [2:0] CFG_SPEED_REGISTER = 3'd2;
  localparam logic [2:0] CFG_BASE_SPEED     = 3'd3;
  localparam logic [2:0] CFG_SPEED_BOOST    = 3'd4;
  localparam logic [2:0] CFG_SPEED_SCALE    = 3'd5;

  // Configuration reset values.
  localparam logic [7:0]  RST_DEVICE_ADDRESS = 8'd1;
  localparam logic [15:0] RST_RUN_REGISTER   = 16'd0;
  localparam logic [15:0] RST_SPEED_REGISTER = 16'd1;
  localparam logic [13:0] RST_BASE_SPEED     = 14'd0;
  localparam logic [13:0] RST_SPEED_BOOST    = 14'd0;
  localparam logic [13:0] RST_SPEED_SCALE    = 14'd100;

  // Drive phases.
  localparam logic [1:0] PH_IDLE       = 2'd0;
  localparam logic [1:0] PH_ACTIVATING = 2'd1;
  localparam logic [1:0] PH_FREQ       = 2'd2;
  localparam logic [1:0] PH_DEACT      = 2'd3;

  // Values written to the run/stop register.
  localparam logic [15:0] RUN_VALUE  = 16'd1;
  localparam logic [15:0] STOP_VALUE = 16'd6;

  // Division by 100 is a shift by two and a division by 25.
  // RECIP_25 is floor(2^32 / 25); the estimate is low by at most one.
  localparam logic [27:0] RECIP_25   = 28'd171798691;
  localparam logic [26:0] DIVISOR_25 = 27'd25;

  // Classified item passed from the front to the back.
  typedef struct packed {
    logic        op;
    logic        start_stop;
    logic        done_target;
    logic        done_ok;
    logic [15:0] setpoint;
  } dss_item_t;

  // One result beat.
  typedef struct packed {
    logic        cmd_valid;
    logic [7:0]  device;
    logic [15:0] regnum;
    logic [15:0] value;
    logic        last;
    logic [1:0]  phase;
    logic        fault;
    logic        running;
  } dss_result_t;

endpackage

`default_nettype wire

### hw/rtl/dss_front.sv
// Front end: accepts input beats and computes the frequency setpoint in a
// short pipeline. Depends on dss_pkg; feeds dss_queue.
`default_nettype none

module dss_front #(
  parameter int DEPTH = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [7:0]                   s_tdata,
  input  wire logic                         s_tuser,
  input  wire logic [13:0]                  base_speed,
  input  wire logic [13:0]                  speed_boost,
  input  wire logic [13:0]                  speed_scale,
  input  wire logic [$clog2(DEPTH+1)-1:0]   queue_level,
  output logic                              push,
  output dss_pkg::dss_item_t                push_item
);

  localparam int LW = $clog2(DEPTH + 1);

  logic        v1, v2, v3;
  logic [3:0]  f1, f2, f3;
  logic [14:0] sum1;
  logic [28:0] prod2;
  logic [26:0] x3;
  logic [22:0] qe3;

  logic        accept;
  logic [1:0]  inflight;
  logic [LW:0] total;
  logic [54:0] recip_prod;
  logic [26:0] rem;
  logic [22:0] quot;

  // Credit check: every beat in the pipeline has a queue slot reserved.
  assign inflight = {1'b0, v1} + {1'b0, v2} + {1'b0, v3};
  assign total    = {1'b0, queue_level} + (LW + 1)'(inflight);
  assign s_tready = total < (LW + 1)'(DEPTH);
  assign accept   = s_tvalid && s_tready;

  // Valid bits of the pipeline stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // The quotient estimate is taken from the same product that lands in x3.
  assign recip_prod = 55'(prod2[28:2]) * 55'(dss_pkg::RECIP_25);

  // Payload stages: speed sum, scaled product, quotient estimate.
  always_ff @(posedge clk) begin
    f1   <= {s_tuser, s_tdata[0], s_tdata[2], s_tdata[3]};
    sum1 <= {1'b0, base_speed} + (s_tdata[1] ? {1'b0, speed_boost} : 15'd0);
    f2    <= f1;
    prod2 <= 29'(sum1) * 29'(speed_scale);
    f3  <= f2;
    x3  <= prod2[28:2];
    qe3 <= recip_prod[54:32];
  end

  // Final correction of the quotient and saturation to 16 bits.
  always_comb begin
    rem  = x3 - ((27'(qe3) << 4) + (27'(qe3) << 3) + 27'(qe3));
    quot = qe3 + ((rem >= dss_pkg::DIVISOR_25) ? 23'd1 : 23'd0);
    push_item.op          = f3[3];
    push_item.start_stop  = f3[2];
    push_item.done_target = f3[1];
    push_item.done_ok     = f3[0];
    push_item.setpoint    = (quot > 23'd65535) ? 16'hFFFF : quot[15:0];
  end

  assign push = v3;

endmodule

`default_nettype wire

### hw/rtl/dss_queue.sv
// Small first-in first-out queue between the front and back ends.
// Depends on dss_pkg for the item type.
`default_nettype none

module dss_queue #(
  parameter int DEPTH = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire dss_pkg::dss_item_t         push_item,
  input  wire logic                       pop,
  output logic                            not_empty,
  output dss_pkg::dss_item_t              head,
  output logic [$clog2(DEPTH+1)-1:0]      level
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);

  dss_pkg::dss_item_t store [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        level <= level + LW'(1);
      end else if (pop && !push) begin
        level <= level - LW'(1);
      end
    end
  end

  assign not_empty = level != '0;
  assign head      = store[rd_ptr];

endmodule

`default_nettype wire

### hw/rtl/dss_back.sv
// Back end: holds the drive state, carries out each item and emits up to
// two result beats through an output register. Depends on dss_pkg.
`default_nettype none

module dss_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  input  wire dss_pkg::dss_item_t  item,
  output logic                     pop,
  input  wire logic [7:0]          device_address,
  input  wire logic [15:0]         run_register,
  input  wire logic [15:0]         speed_register,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output dss_pkg::dss_result_t     out_result
);

  // Drive state.
  logic [1:0]  phase;
  logic        wanted_run, confirmed_run;
  logic [15:0] wanted_speed, confirmed_speed;
  logic        run_pend, speed_pend;
  logic        fault;

  logic [1:0]  phase_next;
  logic        wanted_run_next, confirmed_run_next;
  logic [15:0] wanted_speed_next, confirmed_speed_next;
  logic        run_pend_next, speed_pend_next;
  logic        fault_next;

  logic        run_issue, speed_issue;
  logic [15:0] run_value, speed_value;

  logic                 hold_valid;
  dss_pkg::dss_result_t hold_result;
  dss_pkg::dss_result_t first, second, run_cmd, speed_cmd, status;
  logic                 out_free;

  // Carry out one item against the current state.
  always_comb begin
    phase_next           = phase;
    wanted_run_next      = wanted_run;
    confirmed_run_next   = confirmed_run;
    wanted_speed_next    = wanted_speed;
    confirmed_speed_next = confirmed_speed;
    run_pend_next        = run_pend;
    speed_pend_next      = speed_pend;
    fault_next           = fault;
    run_issue            = 1'b0;
    speed_issue          = 1'b0;
    run_value            = dss_pkg::STOP_VALUE;
    speed_value          = item.setpoint;

    if (item.op) begin
      // Write completion report.
      if (item.done_target) begin
        speed_pend_next = 1'b0;
        if (item.done_ok) begin
          confirmed_speed_next = wanted_speed;
        end
      end else begin
        run_pend_next = 1'b0;
        if (item.done_ok) begin
          confirmed_run_next = wanted_run;
        end
      end
      fault_next = !item.done_ok;
    end else begin
      case (phase)
        dss_pkg::PH_IDLE: begin
          if (item.start_stop) begin
            phase_next = dss_pkg::PH_ACTIVATING;
          end
        end
        dss_pkg::PH_ACTIVATING: begin
          wanted_run_next = 1'b1;
          run_value       = dss_pkg::RUN_VALUE;
          if (!run_pend) begin
            run_issue     = 1'b1;
            run_pend_next = 1'b1;
          end
          if (confirmed_run) begin
            phase_next = dss_pkg::PH_FREQ;
          end else if (item.start_stop) begin
            phase_next = dss_pkg::PH_DEACT;
          end else begin
            wanted_speed_next = item.setpoint;
            if (!speed_pend && item.setpoint != confirmed_speed) begin
              speed_issue     = 1'b1;
              speed_pend_next = 1'b1;
            end
          end
        end
        dss_pkg::PH_FREQ: begin
          if (item.start_stop) begin
            phase_next = dss_pkg::PH_DEACT;
          end else begin
            wanted_speed_next = item.setpoint;
            if (!speed_pend && item.setpoint != confirmed_speed) begin
              speed_issue     = 1'b1;
              speed_pend_next = 1'b1;
            end
          end
        end
        default: begin
          wanted_run_next = 1'b0;
          if (!run_pend) begin
            run_issue     = 1'b1;
            run_pend_next = 1'b1;
          end
          if (!confirmed_run) begin
            wanted_speed_next = 16'd0;
            speed_value       = 16'd0;
            if (confirmed_speed == 16'd0) begin
              phase_next = dss_pkg::PH_IDLE;
            end else if (!speed_pend) begin
              speed_issue     = 1'b1;
              speed_pend_next = 1'b1;
            end
          end
        end
      endcase
    end
  end

  // Build the result beats for this item.
  always_comb begin
    status           = '0;
    status.phase     = phase_next;
    status.fault     = fault_next;
    status.running   = confirmed_run_next;
    status.last      = 1'b1;

    run_cmd           = status;
    run_cmd.cmd_valid = 1'b1;
    run_cmd.device    = device_address;
    run_cmd.regnum    = run_register;
    run_cmd.value     = run_value;

    speed_cmd           = status;
    speed_cmd.cmd_valid = 1'b1;
    speed_cmd.device    = device_address;
    speed_cmd.regnum    = speed_register;
    speed_cmd.value     = speed_value;

    if (run_issue) begin
      first      = run_cmd;
      first.last = !speed_issue;
    end else if (speed_issue) begin
      first = speed_cmd;
    end else begin
      first = status;
    end
    second = speed_cmd;
  end

  // An item is taken only when the output register and hold stage can
  // absorb every beat it makes.
  assign out_free = !out_valid || out_ready;
  assign pop      = item_valid && !hold_valid && out_free;

  // State update.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= dss_pkg::PH_IDLE;
      wanted_run      <= 1'b0;
      confirmed_run   <= 1'b0;
      wanted_speed    <= 16'd0;
      confirmed_speed <= 16'd0;
      run_pend        <= 1'b0;
      speed_pend      <= 1'b0;
      fault           <= 1'b0;
    end else if (pop) begin
      phase           <= phase_next;
      wanted_run      <= wanted_run_next;
      confirmed_run   <= confirmed_run_next;
      wanted_speed    <= wanted_speed_next;
      confirmed_speed <= confirmed_speed_next;
      run_pend        <= run_pend_next;
      speed_pend      <= speed_pend_next;
      fault           <= fault_next;
    end
  end

  // Output register and hold stage for a second beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else if (pop) begin
      out_valid  <= 1'b1;
      hold_valid <= run_issue && speed_issue;
    end else if (hold_valid && out_free) begin
      out_valid  <= 1'b1;
      hold_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_result  <= first;
      hold_result <= second;
    end else if (hold_valid && out_free) begin
      out_result <= hold_result;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/drive_start_stop_sequencer.sv
// Drive start/stop sequencer. An accepted input beat passes the front pipeline,
// queue and back end output register before its result beat appears. Throughput:
// one input beat per cycle while s_tready is high and one result beat per cycle
// while m_tready is high; an input that issues two commands gives two result beats.
// The rate is set by the single result port. Reset (rst, synchronous) clears the
// drive state and queue and returns every configuration register to its default.
`default_nettype none

module drive_start_stop_sequencer #(
  parameter int QUEUE_DEPTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,  // start_stop, speed_select, done_target, done_ok, pad
  input  wire logic        s_tuser,  // operation
  // Result stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,  // command_device, command_register, command_value,
                                     // phase, fault, drive_running, pad
  output logic             m_tuser,  // command_valid
  output logic             m_tlast,  // last_result
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int LW = $clog2(QUEUE_DEPTH + 1);

  logic [7:0]  device_address;
  logic [15:0] run_register, speed_register;
  logic [13:0] base_speed, speed_boost, speed_scale;

  logic                 push, pop, not_empty;
  dss_pkg::dss_item_t   push_item, head;
  logic [LW-1:0]        level;
  dss_pkg::dss_result_t result;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= dss_pkg::RST_DEVICE_ADDRESS;
      run_register   <= dss_pkg::RST_RUN_REGISTER;
      speed_register <= dss_pkg::RST_SPEED_REGISTER;
      base_speed     <= dss_pkg::RST_BASE_SPEED;
      speed_boost    <= dss_pkg::RST_SPEED_BOOST;
      speed_scale    <= dss_pkg::RST_SPEED_SCALE;
    end else if (cfg_we) begin
      case (cfg_index)
        dss_pkg::CFG_DEVICE_ADDRESS: device_address <= cfg_data[7:0];
        dss_pkg::CFG_RUN_REGISTER:   run_register   <= cfg_data;
        dss_pkg::CFG_SPEED_REGISTER: speed_register <= cfg_data;
        dss_pkg::CFG_BASE_SPEED:     base_speed     <= cfg_data[13:0];
        dss_pkg::CFG_SPEED_BOOST:    speed_boost    <= cfg_data[13:0];
        dss_pkg::CFG_SPEED_SCALE:    speed_scale    <= cfg_data[13:0];
        default: begin
        end
      endcase
    end
  end

  dss_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .base_speed  (base_speed),
    .speed_boost (speed_boost),
    .speed_scale (speed_scale),
    .queue_level (level),
    .push        (push),
    .push_item   (push_item)
  );

  dss_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head),
    .level     (level)
  );

  dss_back u_back (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (not_empty),
    .item           (head),
    .pop            (pop),
    .device_address (device_address),
    .run_register   (run_register),
    .speed_register (speed_register),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_result     (result)
  );

  // Pack the result beat.
  assign m_tdata = {4'd0, result.running, result.fault, result.phase,
                    result.value, result.regnum, result.device};
  assign m_tuser = result.cmd_valid;
  assign m_tlast = result.last;

endmodule

`default_nettype wire

### hw/rtl/dss_checker.sv
// Port-level checks for the drive start/stop sequencer, bound to the top.
// Depends only on the top level's ports.
`default_nettype none

module dss_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata,
  input wire logic        m_tuser,
  input wire logic        m_tlast
);

  // No result beat is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat offered right after reset");

  // A stalled result beat holds its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result beat changed");

  // The first of two beats is always the run/stop command.
  a_first_is_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser && (m_tdata[39:24] == 16'd1 ||
      m_tdata[39:24] == 16'd6))
    else $error("first of two beats is not a run/stop command");

  // A beat without a command is the only beat of its item and carries zeros in its command fields.
  a_null_beat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast && m_tdata[39:0] == 40'd0)
    else $error("beat without a command is malformed");

  // The second beat of an item follows its first without a gap.
  a_pair: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("second beat did not follow the first");

endmodule

bind drive_start_stop_sequencer dss_checker u_dss_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire
